/* design/bso16_pkg.sv */
`default_nettype none

package bso16_pkg;

   localparam int unsigned DataWidth   = 16;
   localparam int unsigned TimeWidth   = 32;
   localparam int unsigned CsrWidth    = 32;
   localparam int unsigned AddrWidth   = 5;
   localparam int unsigned NumStages   = 6;

   localparam logic [15:0] TempoReset  = 16'd60;
   localparam logic [15:0] LowReset    = 16'd0;
   localparam logic [15:0] HighReset   = 16'd65535;
   localparam logic [31:0] OriginReset = 32'd0;
   localparam logic [15:0] ShiftReset  = 16'd0;

   localparam logic [15:0] BeatScale   = 16'd280;
   localparam logic [15:0] SineBias    = 16'h8000;
   localparam logic [10:0] QuarterMax  = 11'd2047;
   localparam logic [15:0] WholeBpmLim = 16'd256;

   typedef enum logic [2:0] {
      REG_TEMPO  = 3'd0,
      REG_LOW    = 3'd1,
      REG_HIGH   = 3'd2,
      REG_ORIGIN = 3'd3,
      REG_SHIFT  = 3'd4
   } reg_index_type;

   function automatic logic [15:0] seg_base(input logic [2:0] sec);
      logic [15:0] val;
      case (sec)
         3'd0: val = 16'd0;
         3'd1: val = 16'd6393;
         3'd2: val = 16'd12539;
         3'd3: val = 16'd18204;
         3'd4: val = 16'd23170;
         3'd5: val = 16'd27245;
         3'd6: val = 16'd30273;
         default: val = 16'd32137;
      endcase
      return val;
   endfunction

   function automatic logic [5:0] seg_slope(input logic [2:0] sec);
      logic [5:0] val;
      case (sec)
         3'd0: val = 6'd49;
         3'd1: val = 6'd48;
         3'd2: val = 6'd44;
         3'd3: val = 6'd38;
         3'd4: val = 6'd31;
         3'd5: val = 6'd23;
         3'd6: val = 6'd14;
         default: val = 6'd4;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

/* design/beat_sine_oscillator_16_top.sv */
// beat-synchronized sine oscillator, 16 bit
// input channel (req_valid/req_ready, req_now_ms): one millisecond time stamp
// per transaction. result channel (rsp_valid/rsp_ready, rsp_wave_value): one
// value per transaction, in order, swinging between low_bound and high_bound
// at the programmed tempo
// csr port: apb-style, tempo at 0x00, low_bound 0x04, high_bound 0x08,
// time_origin 0x0c, phase_shift 0x10; pready is always high, program while idle
// six-stage pipeline: subtract origin, 32x16 multiply by tempo, scale by 280
// and add phase, piecewise linear sine, range multiply, add low bound into the
// output register
// an accepted transaction moves through the stage registers in order and shows
// on rsp_valid from the output register; throughput one transaction per cycle
// while rsp_ready is high, set by the fully pipelined datapath with at most one multiplier per stage
// a stalled receiver holds the output; empty stages behind it keep filling, so
// req_ready drops only once all six stages hold a transaction
// reset (synchronous, active high) empties the pipeline and loads the
// registers with tempo 60, bounds 0 and 65535, origin 0, phase 0
`default_nettype none

module beat_sine_oscillator_16_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [bso16_pkg::TimeWidth-1:0]      req_now_ms,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [bso16_pkg::DataWidth-1:0]           rsp_wave_value,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [bso16_pkg::AddrWidth-1:0]      paddr,
   input  wire logic [bso16_pkg::CsrWidth-1:0]       pwdata,
   output logic [bso16_pkg::CsrWidth-1:0]            prdata,
   output logic                                      pready
);

   localparam int unsigned N = bso16_pkg::NumStages;

   logic [15:0] tempo_ff, low_ff, high_ff, shift_ff;
   logic [31:0] origin_ff;
   logic [2:0]  reg_idx;
   logic        csr_wr;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tempo_ff  <= bso16_pkg::TempoReset;
         low_ff    <= bso16_pkg::LowReset;
         high_ff   <= bso16_pkg::HighReset;
         origin_ff <= bso16_pkg::OriginReset;
         shift_ff  <= bso16_pkg::ShiftReset;
      end else if (csr_wr) begin
         unique case (reg_idx)
            bso16_pkg::REG_TEMPO:  tempo_ff  <= pwdata[15:0];
            bso16_pkg::REG_LOW:    low_ff    <= pwdata[15:0];
            bso16_pkg::REG_HIGH:   high_ff   <= pwdata[15:0];
            bso16_pkg::REG_ORIGIN: origin_ff <= pwdata[31:0];
            bso16_pkg::REG_SHIFT:  shift_ff  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         bso16_pkg::REG_TEMPO:  prdata = {16'd0, tempo_ff};
         bso16_pkg::REG_LOW:    prdata = {16'd0, low_ff};
         bso16_pkg::REG_HIGH:   prdata = {16'd0, high_ff};
         bso16_pkg::REG_ORIGIN: prdata = origin_ff;
         bso16_pkg::REG_SHIFT:  prdata = {16'd0, shift_ff};
         default:               prdata = '0;
      endcase
   end

   // pipeline control
   logic [N-1:0] vld_ff, vld_in, stg_ready;

   always_comb begin
      stg_ready[N-1] = !vld_ff[N-1] || rsp_ready;
      for (int k = N - 2; k >= 0; k--) begin
         stg_ready[k] = !vld_ff[k] || stg_ready[k+1];
      end
      vld_in[0] = stg_ready[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < N; k++) begin
         if (stg_ready[k]) begin
            vld_in[k] = vld_ff[k-1];
         end else begin
            vld_in[k] = vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = stg_ready[0];
   assign rsp_valid = vld_ff[N-1];

   // stage 1: elapsed time and tempo in q8.8
   logic [31:0] s1_diff_ff, s1_diff_in;
   logic [15:0] s1_bpm_ff, s1_bpm_in;
   assign s1_diff_in = req_now_ms - origin_ff;
   assign s1_bpm_in  = (tempo_ff < bso16_pkg::WholeBpmLim) ? {tempo_ff[7:0], 8'd0} : tempo_ff;

   // stage 2: elapsed times tempo, low 32 bits
   logic [31:0] s2_prod_ff, s2_prod_in;
   logic [47:0] s2_full;
   assign s2_full    = s1_diff_ff * s1_bpm_ff;
   assign s2_prod_in = s2_full[31:0];

   // stage 3: scale by 280, take product bits 31:16, add phase
   logic [15:0] s3_theta_ff, s3_theta_in;
   logic [47:0] s3_full;
   assign s3_full     = s2_prod_ff * bso16_pkg::BeatScale;
   assign s3_theta_in = s3_full[31:16] + shift_ff;

   // stage 4: piecewise linear sine with quadrant folding, biased
   logic [15:0] s4_sine_ff, s4_sine_in;
   logic [10:0] s4_off;
   logic [2:0]  s4_sec;
   logic [6:0]  s4_sub;
   logic [15:0] s4_mag;
   always_comb begin
      s4_off = s3_theta_ff[13:3];
      if (s3_theta_ff[14]) begin
         s4_off = bso16_pkg::QuarterMax - s4_off;
      end
      s4_sec = s4_off[10:8];
      s4_sub = s4_off[7:1];
      s4_mag = ({10'd0, bso16_pkg::seg_slope(s4_sec)} * {9'd0, s4_sub})
               + bso16_pkg::seg_base(s4_sec);
      if (s3_theta_ff[15]) begin
         s4_sine_in = bso16_pkg::SineBias - s4_mag;
      end else begin
         s4_sine_in = bso16_pkg::SineBias + s4_mag;
      end
   end

   // stage 5: scale to the range
   logic [15:0] s5_scaled_ff, s5_scaled_in;
   logic [16:0] s5_span;
   logic [32:0] s5_full;
   assign s5_span      = {1'b0, 16'(high_ff - low_ff)} + 17'd1;
   assign s5_full      = s4_sine_ff * s5_span;
   assign s5_scaled_in = s5_full[31:16];

   // stage 6: add low bound into the output register
   logic [15:0] s6_out_ff, s6_out_in;
   assign s6_out_in = low_ff + s5_scaled_ff;

   always_ff @(posedge clock) begin
      if (stg_ready[0]) begin
         s1_diff_ff <= s1_diff_in;
         s1_bpm_ff  <= s1_bpm_in;
      end
      if (stg_ready[1]) begin
         s2_prod_ff <= s2_prod_in;
      end
      if (stg_ready[2]) begin
         s3_theta_ff <= s3_theta_in;
      end
      if (stg_ready[3]) begin
         s4_sine_ff <= s4_sine_in;
      end
      if (stg_ready[4]) begin
         s5_scaled_ff <= s5_scaled_in;
      end
      if (stg_ready[5]) begin
         s6_out_ff <= s6_out_in;
      end
   end

   assign rsp_wave_value = s6_out_ff;

   // an empty pipeline always takes a transaction
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      (vld_ff == '0) |-> req_ready)
      else $error("pipeline empty but not ready");

   // a transaction in the stage before the output stage moves into it when the output stage can take it
   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[N-2] && stg_ready[N-1]) |=> vld_ff[N-1])
      else $error("transaction lost between last two stages");

   // input transaction shows up in stage one
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[0])
      else $error("accepted transaction not captured");

   // csr write to tempo lands
   a_tempo_wr: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && reg_idx == bso16_pkg::REG_TEMPO) |=> (tempo_ff == $past(pwdata[15:0])))
      else $error("tempo write not taken");

endmodule

`default_nettype wire
